// File: design/register_dump_delta_encoder_unit_macros.svh
// ---------------------------------------------------------------------------
// register dump delta encoder assertion macros
// concurrent check wrappers, compiled out for synthesis
// ---------------------------------------------------------------------------
`ifndef REGISTER_DUMP_DELTA_ENCODER_UNIT_MACROS_SVH
`define REGISTER_DUMP_DELTA_ENCODER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off during reset
`define RDDE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RDDE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RDDE_ASSERT_NOW(label, ante, cons, msg)
`define RDDE_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: design/rdde_pkg.sv
// ---------------------------------------------------------------------------
// rdde_pkg
// shared widths, constants and types of the register dump delta encoder
// ---------------------------------------------------------------------------
`default_nettype none

package rdde_pkg;

  // fixed field widths
  localparam int BYTE_W    = 8;
  localparam int IDX_OUT_W = 7;
  localparam int SLOT_W    = 2;
  localparam int ACT_W     = 1;

  // input action codes
  localparam logic [ACT_W-1:0] ACT_WRITE = 1'b0;
  localparam logic [ACT_W-1:0] ACT_FRAME = 1'b1;

  // value a sent copy holds after reset
  localparam logic [BYTE_W-1:0] SENT_RESET_VAL = 8'hFF;

  // one (index, value) pair of the delta stream
  typedef struct packed {
    logic [IDX_OUT_W-1:0] idx;
    logic [BYTE_W-1:0]    val;
  } pair_t;

endpackage

`default_nettype wire

// File: design/register_dump_delta_encoder_unit.sv
// Write item: accepted while idle, no result.
// Frame-end item: each scanned register takes a table read, then a compare and
// update, over chips*REGS_PER_CHIP registers, and the last result is then
// flushed; the scan may wait while the output is stalled.
// in_ready is low during a scan. Synchronous active-low reset; per-entry valid
// bits give the table reset values at once, with no clearing pass.
// ---------------------------------------------------------------------------
// register_dump_delta_encoder_unit
// tracks sound-chip register writes and emits changed registers per frame,
// up to two (index, value) pairs per result, last result flagged as frame end
// ---------------------------------------------------------------------------
`default_nettype none

`include "register_dump_delta_encoder_unit_macros.svh"

module register_dump_delta_encoder_unit #(
  parameter int REGS_PER_CHIP = 25,
  parameter int MAX_CHIPS     = 3
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // configuration
  input  wire logic                           cfg_wr_en,
  input  wire logic [rdde_pkg::SLOT_W-1:0]    cfg_wr_data,
  // input channel
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [rdde_pkg::ACT_W-1:0]     in_action,
  input  wire logic [rdde_pkg::SLOT_W-1:0]    in_chip_slot,
  input  wire logic [rdde_pkg::BYTE_W-1:0]    in_reg_number,
  input  wire logic [rdde_pkg::BYTE_W-1:0]    in_reg_value,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_first_valid,
  output logic [rdde_pkg::IDX_OUT_W-1:0]      out_first_index,
  output logic [rdde_pkg::BYTE_W-1:0]         out_first_byte,
  output logic                                out_second_valid,
  output logic [rdde_pkg::IDX_OUT_W-1:0]      out_second_index,
  output logic [rdde_pkg::BYTE_W-1:0]         out_second_byte,
  output logic                                out_frame_end
);

  import rdde_pkg::*;

  localparam int TABLE_SIZE = MAX_CHIPS * REGS_PER_CHIP;
  localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int ADDR_CALC_W = 8;

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_CMP   = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0]            state_r,     state_nxt;
  logic [SLOT_W-1:0]     chips_r;
  logic [IDX_W-1:0]      scan_idx_r,  scan_idx_nxt;
  logic [IDX_W-1:0]      scan_last_r, scan_last_nxt;
  logic [1:0]            bld_cnt_r,   bld_cnt_nxt;
  pair_t                 bld_a_r,     bld_a_nxt;
  pair_t                 bld_b_r,     bld_b_nxt;

  logic                  out_valid_r,        out_valid_nxt;
  logic                  out_first_valid_r,  out_first_valid_nxt;
  pair_t                 out_first_r,        out_first_nxt;
  logic                  out_second_valid_r, out_second_valid_nxt;
  pair_t                 out_second_r,       out_second_nxt;
  logic                  out_frame_end_r,    out_frame_end_nxt;

  // register tables and their valid bits
  logic [BYTE_W-1:0]     cur_mem_r  [TABLE_SIZE];
  logic [BYTE_W-1:0]     sent_mem_r [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] cur_vld_r;
  logic [TABLE_SIZE-1:0] sent_vld_r;
  logic [BYTE_W-1:0]     cur_rd_r;
  logic [BYTE_W-1:0]     sent_rd_r;
  logic                  cur_rdv_r;
  logic                  sent_rdv_r;

  logic [SLOT_W-1:0]      eff_chips;
  logic [ADDR_CALC_W-1:0] wr_addr_full;
  logic [IDX_W-1:0]       wr_addr;
  logic                   wr_ok;
  logic [ADDR_CALC_W-1:0] last_full;
  logic                   cur_we;
  logic                   sent_we;
  logic                   rd_en;
  logic [BYTE_W-1:0]      cmp_cur;
  logic [BYTE_W-1:0]      cmp_sent;
  logic                   diff;
  logic                   out_free;
  logic                   out_load;
  logic                   out_fe_load;
  pair_t                  new_pair;

  // chip count clamp
  always_comb begin
    if (chips_r == '0) begin
      eff_chips = SLOT_W'(1);
    end else if (chips_r > SLOT_W'(MAX_CHIPS)) begin
      eff_chips = SLOT_W'(MAX_CHIPS);
    end else begin
      eff_chips = chips_r;
    end
  end

  // write address and range check
  assign wr_addr_full = ADDR_CALC_W'(in_chip_slot) * ADDR_CALC_W'(REGS_PER_CHIP)
                      + in_reg_number;
  assign wr_addr      = wr_addr_full[IDX_W-1:0];
  assign wr_ok        = (in_reg_number < ADDR_CALC_W'(REGS_PER_CHIP))
                        && (in_chip_slot < eff_chips);

  // last table index of a scan
  assign last_full = ADDR_CALC_W'(eff_chips) * ADDR_CALC_W'(REGS_PER_CHIP)
                   - ADDR_CALC_W'(1);

  // compare unit on the registered table reads
  assign cmp_cur  = cur_rdv_r  ? cur_rd_r  : '0;
  assign cmp_sent = sent_rdv_r ? sent_rd_r : SENT_RESET_VAL;
  assign diff     = (cmp_cur != cmp_sent);
  assign new_pair = '{idx: IDX_OUT_W'(scan_idx_r), val: cmp_cur};

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    scan_idx_nxt  = scan_idx_r;
    scan_last_nxt = scan_last_r;
    bld_cnt_nxt   = bld_cnt_r;
    bld_a_nxt     = bld_a_r;
    bld_b_nxt     = bld_b_r;
    cur_we        = 1'b0;
    sent_we       = 1'b0;
    rd_en         = 1'b0;
    out_load      = 1'b0;
    out_fe_load   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_action == ACT_FRAME) begin
            scan_idx_nxt  = '0;
            scan_last_nxt = last_full[IDX_W-1:0];
            bld_cnt_nxt   = 2'd0;
            state_nxt     = ST_READ;
          end else begin
            cur_we = wr_ok;
          end
        end
      end
      ST_READ: begin
        rd_en     = 1'b1;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        // a third pair needs the output register for the two held ones
        if (!(diff && (bld_cnt_r == 2'd2) && !out_free)) begin
          if (diff) begin
            sent_we = 1'b1;
            case (bld_cnt_r)
              2'd0: begin
                bld_a_nxt   = new_pair;
                bld_cnt_nxt = 2'd1;
              end
              2'd1: begin
                bld_b_nxt   = new_pair;
                bld_cnt_nxt = 2'd2;
              end
              default: begin
                out_load    = 1'b1;
                bld_a_nxt   = new_pair;
                bld_cnt_nxt = 2'd1;
              end
            endcase
          end
          if (scan_idx_r == scan_last_r) begin
            state_nxt = ST_FLUSH;
          end else begin
            scan_idx_nxt = scan_idx_r + IDX_W'(1);
            state_nxt    = ST_READ;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_fe_load = 1'b1;
          bld_cnt_nxt = 2'd0;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output register load from the held pairs
  always_comb begin
    out_valid_nxt        = out_valid_r;
    out_first_valid_nxt  = out_first_valid_r;
    out_first_nxt        = out_first_r;
    out_second_valid_nxt = out_second_valid_r;
    out_second_nxt       = out_second_r;
    out_frame_end_nxt    = out_frame_end_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt        = 1'b1;
      out_first_valid_nxt  = (bld_cnt_r != 2'd0);
      out_first_nxt        = (bld_cnt_r != 2'd0) ? bld_a_r : '0;
      out_second_valid_nxt = (bld_cnt_r == 2'd2);
      out_second_nxt       = (bld_cnt_r == 2'd2) ? bld_b_r : '0;
      out_frame_end_nxt    = out_fe_load;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      chips_r     <= SLOT_W'(1);
      bld_cnt_r   <= 2'd0;
      out_valid_r <= 1'b0;
      cur_vld_r   <= '0;
      sent_vld_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      bld_cnt_r   <= bld_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        chips_r <= cfg_wr_data;
      end
      if (cur_we) begin
        cur_vld_r[wr_addr] <= 1'b1;
      end
      if (sent_we) begin
        sent_vld_r[scan_idx_r] <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    scan_idx_r         <= scan_idx_nxt;
    scan_last_r        <= scan_last_nxt;
    bld_a_r            <= bld_a_nxt;
    bld_b_r            <= bld_b_nxt;
    out_first_valid_r  <= out_first_valid_nxt;
    out_first_r        <= out_first_nxt;
    out_second_valid_r <= out_second_valid_nxt;
    out_second_r       <= out_second_nxt;
    out_frame_end_r    <= out_frame_end_nxt;
  end

  // table memories, registered reads
  always_ff @(posedge clk) begin
    if (cur_we) begin
      cur_mem_r[wr_addr] <= in_reg_value;
    end
    if (sent_we) begin
      sent_mem_r[scan_idx_r] <= cmp_cur;
    end
    if (rd_en) begin
      cur_rd_r   <= cur_mem_r[scan_idx_r];
      sent_rd_r  <= sent_mem_r[scan_idx_r];
      cur_rdv_r  <= cur_vld_r[scan_idx_r];
      sent_rdv_r <= sent_vld_r[scan_idx_r];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_first_valid  = out_first_valid_r;
  assign out_first_index  = out_first_r.idx;
  assign out_first_byte   = out_first_r.val;
  assign out_second_valid = out_second_valid_r;
  assign out_second_index = out_second_r.idx;
  assign out_second_byte  = out_second_r.val;
  assign out_frame_end    = out_frame_end_r;

  // checks
  `RDDE_ASSERT_NEXT(a_frame_starts_scan, in_valid && in_ready && (in_action == ACT_FRAME), state_r == ST_READ, "frame-end item did not start a scan")
  `RDDE_ASSERT_NOW(a_bld_cnt_range, 1'b1, bld_cnt_r != 2'd3, "pair count beyond two")
  `RDDE_ASSERT_NOW(a_empty_is_term, out_valid_r && !out_first_valid_r, out_frame_end_r && !out_second_valid_r, "empty result that is not the frame terminator")
  `RDDE_ASSERT_NOW(a_scan_in_range, state_r != ST_IDLE, scan_idx_r <= scan_last_r, "scan index past the last register")

endmodule

`default_nettype wire

// File: sim/testbench.sv
// ---------------------------------------------------------------------------
// register dump delta encoder testbench
// drives register writes and frame ends through the valid/ready handshake,
// predicts the changed-register pair stream per frame and checks every
// result field against it, over several chip counts and idle patterns
// ---------------------------------------------------------------------------
module testbench;
  import rdde_pkg::*;

  localparam int REGS_PER_CHIP = 25;
  localparam int MAX_CHIPS     = 3;
  localparam int TABLE_SIZE    = REGS_PER_CHIP * MAX_CHIPS;
  // longest scan of a frame plus its flush
  localparam int SETTLE_CYCLES = 2 * MAX_CHIPS * REGS_PER_CHIP + 2;
  localparam int PHASE_ITEMS   = 74;
  localparam int NUM_PHASES    = 6;
  localparam int SCRIPT_LEN    = 19;
  localparam int TIMEOUT       = 7_000_000;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // one result of the delta stream
  typedef struct packed {
    logic                 first_valid;
    logic [IDX_OUT_W-1:0] first_index;
    logic [BYTE_W-1:0]    first_byte;
    logic                 second_valid;
    logic [IDX_OUT_W-1:0] second_index;
    logic [BYTE_W-1:0]    second_byte;
    logic                 frame_end;
  } delta_word_t;

  // one input item, with an optional hand-typed result
  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [SLOT_W-1:0] slot;
    logic [BYTE_W-1:0] reg_no;
    logic [BYTE_W-1:0] value;
    logic              typed;
    delta_word_t       want;
  } stim_row_t;

  localparam delta_word_t NO_WORD     = '0;
  localparam delta_word_t QUIET_FRAME = '{1'b0, 7'd0, 8'h00, 1'b0, 7'd0, 8'h00, 1'b1};

  localparam logic [SLOT_W-1:0] PHASE_CHIPS [NUM_PHASES] = '{2'd3, 2'd0, 2'd2, 2'd3, 2'd1, 2'd3};
  localparam idle_mode_t PHASE_IDLE [NUM_PHASES] =
    '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_SENDER, IDLE_RECEIVER};

  // directed items, one chip in use
  stim_row_t script [SCRIPT_LEN] = '{
    // first frame after reset: every register differs from 0xFF
    '{ACT_FRAME, 2'd0, 8'd0,   8'h00, 1'b0, NO_WORD},
    '{ACT_FRAME, 2'd0, 8'd0,   8'h00, 1'b1, QUIET_FRAME},
    // lowest and highest register, byte extremes
    '{ACT_WRITE, 2'd0, 8'd0,   8'hFF, 1'b0, NO_WORD},
    '{ACT_WRITE, 2'd0, 8'd24,  8'h80, 1'b0, NO_WORD},
    '{ACT_FRAME, 2'd3, 8'hFF,  8'hFF, 1'b1,
      '{1'b1, 7'd0, 8'hFF, 1'b1, 7'd24, 8'h80, 1'b1}},
    // register out of range and chip not in use are dropped
    '{ACT_WRITE, 2'd0, 8'd25,  8'h12, 1'b0, NO_WORD},
    '{ACT_WRITE, 2'd0, 8'd255, 8'hAA, 1'b0, NO_WORD},
    '{ACT_WRITE, 2'd1, 8'd3,   8'h77, 1'b0, NO_WORD},
    '{ACT_WRITE, 2'd3, 8'd0,   8'h01, 1'b0, NO_WORD},
    '{ACT_FRAME, 2'd0, 8'd0,   8'h00, 1'b1, QUIET_FRAME},
    // odd count leaves the second slot empty
    '{ACT_WRITE, 2'd0, 8'd5,   8'h5A, 1'b0, NO_WORD},
    '{ACT_FRAME, 2'd0, 8'd0,   8'h00, 1'b1,
      '{1'b1, 7'd5, 8'h5A, 1'b0, 7'd0, 8'h00, 1'b1}},
    // written back to the sent value: no change
    '{ACT_WRITE, 2'd0, 8'd7,   8'h01, 1'b0, NO_WORD},
    '{ACT_WRITE, 2'd0, 8'd7,   8'h00, 1'b0, NO_WORD},
    '{ACT_FRAME, 2'd0, 8'd0,   8'h00, 1'b1, QUIET_FRAME},
    // three changes span two results
    '{ACT_WRITE, 2'd0, 8'd10,  8'hA5, 1'b0, NO_WORD},
    '{ACT_WRITE, 2'd0, 8'd11,  8'h3C, 1'b0, NO_WORD},
    '{ACT_WRITE, 2'd0, 8'd12,  8'hC3, 1'b0, NO_WORD},
    '{ACT_FRAME, 2'd0, 8'd0,   8'h00, 1'b0, NO_WORD}
  };

  logic                 clk              = 1'b0;
  logic                 rst_n            = 1'b0;
  logic                 cfg_wr_en        = 1'b0;
  logic [SLOT_W-1:0]    cfg_wr_data      = '0;
  logic                 in_valid         = 1'b0;
  logic                 in_ready;
  logic [ACT_W-1:0]     in_action        = ACT_WRITE;
  logic [SLOT_W-1:0]    in_chip_slot     = '0;
  logic [BYTE_W-1:0]    in_reg_number    = '0;
  logic [BYTE_W-1:0]    in_reg_value     = '0;
  logic                 out_valid;
  logic                 out_ready        = 1'b0;
  logic                 out_first_valid;
  logic [IDX_OUT_W-1:0] out_first_index;
  logic [BYTE_W-1:0]    out_first_byte;
  logic                 out_second_valid;
  logic [IDX_OUT_W-1:0] out_second_index;
  logic [BYTE_W-1:0]    out_second_byte;
  logic                 out_frame_end;

  // predictor state
  logic [BYTE_W-1:0] live_regs [TABLE_SIZE];
  logic [BYTE_W-1:0] sent_copy [TABLE_SIZE];
  logic [SLOT_W-1:0] chip_setting;
  delta_word_t       expected_words [$];

  idle_mode_t idle_mode  = IDLE_NONE;
  int         fail_count = 0;

  register_dump_delta_encoder_unit #(
    .REGS_PER_CHIP (REGS_PER_CHIP),
    .MAX_CHIPS     (MAX_CHIPS)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_chip_slot     (in_chip_slot),
    .in_reg_number    (in_reg_number),
    .in_reg_value     (in_reg_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_first_valid  (out_first_valid),
    .out_first_index  (out_first_index),
    .out_first_byte   (out_first_byte),
    .out_second_valid (out_second_valid),
    .out_second_index (out_second_index),
    .out_second_byte  (out_second_byte),
    .out_frame_end    (out_frame_end)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  initial begin
    #TIMEOUT;
    $display("CHECKS FAILED");
    $finish;
  end

  // chip count with zero read as one and overflow clamped
  function automatic int active_chips();
    if (chip_setting == 0) return 1;
    if (chip_setting > MAX_CHIPS) return MAX_CHIPS;
    return int'(chip_setting);
  endfunction

  // apply one accepted item to the tables and queue the frame's results
  function automatic void absorb_item(input stim_row_t row);
    delta_word_t frame_words [$];
    delta_word_t word;
    logic        half;
    int          n_chips;
    n_chips = active_chips();
    if (row.action == ACT_WRITE) begin
      if (row.reg_no < REGS_PER_CHIP && row.slot < n_chips)
        live_regs[row.slot * REGS_PER_CHIP + row.reg_no] = row.value;
      return;
    end
    word = '0;
    half = 1'b0;
    for (int i = 0; i < n_chips * REGS_PER_CHIP; i++) begin
      if (live_regs[i] != sent_copy[i]) begin
        sent_copy[i] = live_regs[i];
        if (!half) begin
          word = '0;
          word.first_valid = 1'b1;
          word.first_index = i[IDX_OUT_W-1:0];
          word.first_byte  = live_regs[i];
          half = 1'b1;
        end else begin
          word.second_valid = 1'b1;
          word.second_index = i[IDX_OUT_W-1:0];
          word.second_byte  = live_regs[i];
          frame_words = {frame_words, word};
          half = 1'b0;
        end
      end
    end
    // pending half-filled word or an empty frame
    if (half || frame_words.size() == 0) frame_words = {frame_words, word};
    frame_words[frame_words.size() - 1].frame_end = 1'b1;
    if (row.typed) expected_words = {expected_words, row.want};
    else foreach (frame_words[k]) expected_words = {expected_words, frame_words[k]};
  endfunction

  // random item: mostly live writes, some frame ends, some dropped writes
  function automatic stim_row_t random_item();
    stim_row_t row;
    int        pick;
    row        = '0;
    row.action = ACT_WRITE;
    row.value  = BYTE_W'($urandom_range(255));
    pick       = $urandom_range(99);
    if (pick < 10) begin
      row.action = ACT_FRAME;
      row.slot   = SLOT_W'($urandom_range(3));
      row.reg_no = BYTE_W'($urandom_range(255));
    end else if (pick < 78) begin
      row.slot   = SLOT_W'($urandom_range(active_chips() - 1));
      row.reg_no = BYTE_W'($urandom_range(REGS_PER_CHIP - 1));
      // sometimes rewrite the value it already holds
      if ($urandom_range(7) == 0)
        row.value = live_regs[row.slot * REGS_PER_CHIP + row.reg_no];
    end else if (pick < 88) begin
      row.slot   = SLOT_W'($urandom_range(active_chips() - 1));
      row.reg_no = BYTE_W'($urandom_range(255, REGS_PER_CHIP));
    end else begin
      row.slot   = SLOT_W'($urandom_range(3));
      row.reg_no = BYTE_W'($urandom_range(255));
    end
    return row;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endfunction

  // present one item from a falling edge until it is accepted
  task automatic offer_item(input stim_row_t row);
    int pause_pct;
    pause_pct = (idle_mode == IDLE_SENDER) ? 47 : (idle_mode == IDLE_BOTH) ? 15 : 0;
    while ($urandom_range(99) < pause_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= row.action;
    in_chip_slot  <= row.slot;
    in_reg_number <= row.reg_no;
    in_reg_value  <= row.value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    absorb_item(row);
    @(negedge clk);
  endtask

  task automatic write_chip_count(input logic [SLOT_W-1:0] count);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= count;
    @(posedge clk);
    chip_setting = count;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // wait for the last result, then let any trailing write settle
  task automatic drain_results();
    while (expected_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // result receiver stalls
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >=
                  ((idle_mode == IDLE_RECEIVER) ? 47 : (idle_mode == IDLE_BOTH) ? 15 : 0));
  end

  // result checker
  always @(posedge clk) begin : check_words
    delta_word_t got;
    delta_word_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_first_valid, out_first_index, out_first_byte, out_second_valid,
              out_second_index, out_second_byte, out_frame_end};
      if (expected_words.size() == 0) begin
        fail_count++;
        $display("%0t: result expected none got %h", $time, got);
      end else begin
        want = expected_words.pop_front();
        check_field("first_valid", int'(want.first_valid), int'(got.first_valid));
        check_field("first_index", int'(want.first_index), int'(got.first_index));
        check_field("first_byte", int'(want.first_byte), int'(got.first_byte));
        check_field("second_valid", int'(want.second_valid), int'(got.second_valid));
        check_field("second_index", int'(want.second_index), int'(got.second_index));
        check_field("second_byte", int'(want.second_byte), int'(got.second_byte));
        check_field("frame_end", int'(want.frame_end), int'(got.frame_end));
      end
    end
  end

  // main sequence
  initial begin : run
    stim_row_t row;
    int        done;
    foreach (live_regs[i]) begin
      live_regs[i] = '0;
      sent_copy[i] = SENT_RESET_VAL;
    end
    chip_setting = 2'd1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed items
    write_chip_count(2'd1);
    for (int k = 0; k < SCRIPT_LEN; k++) offer_item(script[k]);
    in_valid <= 1'b0;

    // random phases, one chip count and idle pattern each
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      write_chip_count(PHASE_CHIPS[p]);
      idle_mode = PHASE_IDLE[p];
      done = 0;
      while (done < PHASE_ITEMS) begin
        row = random_item();
        if (done == PHASE_ITEMS - 1) row.action = ACT_FRAME;
        done++;
        offer_item(row);
      end
      in_valid <= 1'b0;
    end

    drain_results();
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
